// ===== rtl/v3alu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types and helpers for the 3-vector arithmetic unit
// Word format, derived widths, opcode names, pipeline stage records and the
// saturation helper used at several points of the datapath.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int W    = 32;        // word width
    localparam int F    = 16;        // fraction bits
    localparam int OPW  = W + 1;     // multiplier operand (holds b - a)
    localparam int PW   = 2 * OPW;   // product width
    localparam int SUMW = PW + 2;    // sum of three products
    localparam int QB   = OPW + 1;   // square root result bits
    localparam int RB   = 2 * QB;    // square root radicand bits
    localparam int NB   = W + F;     // divider numerator bits
    localparam int DB   = QB;        // divider denominator bits
    localparam int REMW = DB + 1;    // divider partial remainder

    localparam logic [W-1:0] WMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SUMW-1:0] SAT_MAX = {{(SUMW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_MIN = {{(SUMW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        FN_ADD    = 5'd0,
        FN_SUB    = 5'd1,
        FN_MUL    = 5'd2,
        FN_DIV    = 5'd3,
        FN_SADD   = 5'd4,
        FN_SSUB   = 5'd5,
        FN_SMUL   = 5'd6,
        FN_SDIV   = 5'd7,
        FN_NEG    = 5'd8,
        FN_DOT    = 5'd9,
        FN_CROSS  = 5'd10,
        FN_MAG    = 5'd11,
        FN_MAGSQ  = 5'd12,
        FN_NORM   = 5'd13,
        FN_ABS    = 5'd14,
        FN_DIST   = 5'd15,
        FN_DISTSQ = 5'd16,
        FN_EQ     = 5'd17
    } func_t;

    // square root section record
    typedef struct packed {
        logic                  valid;
        logic [4:0]            func;
        logic                  eq;
        logic [2:0][W-1:0]     r;
        logic [W-1:0]          sc;
        logic [2:0][W-1:0]     a;
        logic [2:0][DB-1:0]    den;
        logic [2:0]            den_neg;
        logic [RB-1:0]         rad;
        logic [QB+1:0]         rem;
        logic [QB-1:0]         root;
    } sq_t;

    // divider section record
    typedef struct packed {
        logic                  valid;
        logic [4:0]            func;
        logic                  eq;
        logic [2:0][W-1:0]     r;
        logic [W-1:0]          sc;
        logic [2:0][W-1:0]     a;
        logic [2:0][DB-1:0]    den;
        logic [2:0]            neg;
        logic [2:0]            dzc;
        logic [2:0][NB-1:0]    num;
        logic [2:0][REMW-1:0]  rem;
        logic [2:0][NB-1:0]    q;
    } dv_t;

    function automatic logic [W-1:0] sat_w(input logic signed [SUMW-1:0] v);
        logic [W-1:0] res;
        if (v > SAT_MAX) begin
            res = WMAX_W;
        end else if (v < SAT_MIN) begin
            res = WMIN_W;
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    function automatic logic [W-1:0] sat_op(input logic [OPW-1:0] v);
        return sat_w($signed({{(SUMW-OPW){v[OPW-1]}}, v}));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vector3_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit: pipelined ALU for signed fixed-point 3-vectors
// Componentwise, scalar, dot, cross, magnitude, normalize, abs, distance and
// equality operations on Q16.16 words, one opcode per word.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one operation word (opcode, vectors a and b,
//   scalar). The m_ channel returns one result word per operation word,
//   in order. Both channels are valid/ready.
//   Throughput: one word per cycle; a new word is taken every cycle the
//   output side is not stalled.
//   Pipeline: 88 register stages. Three stages form the operands, the
//   products and their sums, one saturates, 34 stages compute the square
//   root one result bit each, 49 stages load and run three restoring
//   dividers (one quotient bit per stage after the loading stage), and the
//   last is the output register.
//   Every opcode travels the full pipeline so results stay in order.
//   Stall: while m_valid is high and m_ready low, the whole pipeline holds
//   and s_ready is low; nothing is dropped or repeated.
//   Reset: aresetn clears every stage valid; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit
    import v3alu_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [4:0]    s_func,
    input  wire logic [W-1:0]  s_a_x,
    input  wire logic [W-1:0]  s_a_y,
    input  wire logic [W-1:0]  s_a_z,
    input  wire logic [W-1:0]  s_b_x,
    input  wire logic [W-1:0]  s_b_y,
    input  wire logic [W-1:0]  s_b_z,
    input  wire logic [W-1:0]  s_scale,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [W-1:0]       m_r_x,
    output logic [W-1:0]       m_r_y,
    output logic [W-1:0]       m_r_z,
    output logic [W-1:0]       m_r_scalar,
    output logic               m_is_equal,
    output logic               m_div_zero
);

    logic adv;
    logic [2:0][W-1:0] a_in, b_in;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign a_in    = {s_a_z, s_a_y, s_a_x};
    assign b_in    = {s_b_z, s_b_y, s_b_x};

    // ---------------- stage 1: operand select and simple results ----------
    logic               v1_reg;
    logic [4:0]         func1_reg;
    logic               eq1_reg;
    logic [2:0][W-1:0]  sr1_reg, sr1_next;
    logic [2:0][OPW-1:0] x1_reg, y1_reg, u1_reg, w1_reg;
    logic [2:0][OPW-1:0] x1_next, y1_next, u1_next, w1_next;
    logic [2:0][W-1:0]  a1_reg;
    logic [2:0][DB-1:0] den1_reg, den1_next;
    logic [2:0]         dneg1_reg, dneg1_next;

    always_comb begin
        int j, k;
        logic [OPW-1:0] ea, eb, es, ed, eaj, ebj, eak, ebk;
        logic [W-1:0] dv;
        for (int i = 0; i < 3; i++) begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            ea  = {a_in[i][W-1], a_in[i]};
            eb  = {b_in[i][W-1], b_in[i]};
            es  = {s_scale[W-1], s_scale};
            ed  = eb - ea;
            eaj = {a_in[j][W-1], a_in[j]};
            ebj = {b_in[j][W-1], b_in[j]};
            eak = {a_in[k][W-1], a_in[k]};
            ebk = {b_in[k][W-1], b_in[k]};
            case (s_func)
                FN_ADD:  sr1_next[i] = sat_op(ea + eb);
                FN_SUB:  sr1_next[i] = sat_op(ea - eb);
                FN_SADD: sr1_next[i] = sat_op(ea + es);
                FN_SSUB: sr1_next[i] = sat_op(ea - es);
                FN_NEG:  sr1_next[i] = sat_op(OPW'(0) - ea);
                FN_ABS:  sr1_next[i] = sat_op(ea[OPW-1] ? OPW'(0) - ea : ea);
                default: sr1_next[i] = '0;
            endcase
            u1_next[i] = '0;
            w1_next[i] = '0;
            case (s_func)
                FN_MUL, FN_DOT: begin
                    x1_next[i] = ea;
                    y1_next[i] = eb;
                end
                FN_SMUL: begin
                    x1_next[i] = ea;
                    y1_next[i] = es;
                end
                FN_CROSS: begin
                    x1_next[i] = eaj;
                    y1_next[i] = ebk;
                    u1_next[i] = ebj;
                    w1_next[i] = eak;
                end
                FN_MAG, FN_MAGSQ, FN_NORM: begin
                    x1_next[i] = ea;
                    y1_next[i] = ea;
                end
                FN_DIST, FN_DISTSQ: begin
                    x1_next[i] = ed;
                    y1_next[i] = ed;
                end
                default: begin
                    x1_next[i] = '0;
                    y1_next[i] = '0;
                end
            endcase
            dv = (s_func == FN_SDIV) ? s_scale : b_in[i];
            dneg1_next[i] = dv[W-1];
            den1_next[i]  = dv[W-1] ? DB'(0) - {{(DB-W){1'b1}}, dv} : {{(DB-W){1'b0}}, dv};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            func1_reg <= s_func;
            eq1_reg   <= (a_in == b_in);
            sr1_reg   <= sr1_next;
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            u1_reg    <= u1_next;
            w1_reg    <= w1_next;
            a1_reg    <= a_in;
            den1_reg  <= den1_next;
            dneg1_reg <= dneg1_next;
        end
    end

    // ---------------- stage 2: products ----------------------------------
    logic               v2_reg;
    logic [4:0]         func2_reg;
    logic               eq2_reg;
    logic [2:0][W-1:0]  sr2_reg;
    logic [2:0][PW-1:0] p2_reg, q2_reg, p2_next, q2_next;
    logic [2:0][W-1:0]  a2_reg;
    logic [2:0][DB-1:0] den2_reg;
    logic [2:0]         dneg2_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p2_next[i] = $signed(x1_reg[i]) * $signed(y1_reg[i]);
            q2_next[i] = $signed(u1_reg[i]) * $signed(w1_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            func2_reg <= func1_reg;
            eq2_reg   <= eq1_reg;
            sr2_reg   <= sr1_reg;
            p2_reg    <= p2_next;
            q2_reg    <= q2_next;
            a2_reg    <= a1_reg;
            den2_reg  <= den1_reg;
            dneg2_reg <= dneg1_reg;
        end
    end

    // ---------------- stage 3: differences and sum -----------------------
    logic                 v3_reg;
    logic [4:0]           func3_reg;
    logic                 eq3_reg;
    logic [2:0][W-1:0]    sr3_reg;
    logic [2:0][SUMW-1:0] vp3_reg, vp3_next;
    logic [SUMW-1:0]      sum3_reg, sum3_next;
    logic [2:0][W-1:0]    a3_reg;
    logic [2:0][DB-1:0]   den3_reg;
    logic [2:0]           dneg3_reg;

    always_comb begin
        logic [2:0][SUMW-1:0] ep, eq_;
        for (int i = 0; i < 3; i++) begin
            ep[i]  = {{(SUMW-PW){p2_reg[i][PW-1]}}, p2_reg[i]};
            eq_[i] = {{(SUMW-PW){q2_reg[i][PW-1]}}, q2_reg[i]};
            vp3_next[i] = (func2_reg == FN_CROSS) ? ep[i] - eq_[i] : ep[i];
        end
        sum3_next = ep[0] + ep[1] + ep[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            func3_reg <= func2_reg;
            eq3_reg   <= eq2_reg;
            sr3_reg   <= sr2_reg;
            vp3_reg   <= vp3_next;
            sum3_reg  <= sum3_next;
            a3_reg    <= a2_reg;
            den3_reg  <= den2_reg;
            dneg3_reg <= dneg2_reg;
        end
    end

    // ---------------- stage 4: saturate, enter square root ---------------
    sq_t sq_reg [0:QB];
    sq_t sq0_next;

    always_comb begin
        sq0_next.valid   = v3_reg;
        sq0_next.func    = func3_reg;
        sq0_next.eq      = eq3_reg;
        sq0_next.a       = a3_reg;
        sq0_next.den     = den3_reg;
        sq0_next.den_neg = dneg3_reg;
        sq0_next.rem     = '0;
        sq0_next.root    = '0;
        for (int i = 0; i < 3; i++) begin
            case (func3_reg)
                FN_MUL, FN_SMUL, FN_CROSS:
                    sq0_next.r[i] = sat_w($signed(vp3_reg[i]) >>> F);
                default: sq0_next.r[i] = sr3_reg[i];
            endcase
        end
        case (func3_reg)
            FN_DOT, FN_MAGSQ, FN_DISTSQ: sq0_next.sc = sat_w($signed(sum3_reg) >>> F);
            default:                     sq0_next.sc = '0;
        endcase
        case (func3_reg)
            FN_MAG, FN_NORM, FN_DIST: sq0_next.rad = sum3_reg;
            default:                  sq0_next.rad = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg[0].valid <= 1'b0;
        end else if (adv) begin
            sq_reg[0] <= sq0_next;
        end
    end

    // one root bit per stage
    function automatic sq_t sqrt_step(input sq_t cur);
        sq_t nxt;
        logic [QB+1:0] rem2, trial;
        nxt   = cur;
        rem2  = {cur.rem[QB-1:0], cur.rad[RB-1 -: 2]};
        trial = {cur.root, 2'b01};
        nxt.rad = {cur.rad[RB-3:0], 2'b00};
        if (rem2 >= trial) begin
            nxt.rem  = rem2 - trial;
            nxt.root = {cur.root[QB-2:0], 1'b1};
        end else begin
            nxt.rem  = rem2;
            nxt.root = {cur.root[QB-2:0], 1'b0};
        end
        return nxt;
    endfunction

    for (genvar k = 0; k < QB; k++) begin : g_sqrt
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_reg[k+1].valid <= 1'b0;
            end else if (adv) begin
                sq_reg[k+1] <= sqrt_step(sq_reg[k]);
            end
        end
    end

    // ---------------- divider entry --------------------------------------
    dv_t dv_reg [0:NB];
    dv_t dv0_next;

    always_comb begin
        sq_t s;
        logic [DB-1:0] dn;
        logic          dng;
        logic [W-1:0]  ma;
        s = sq_reg[QB];
        dv0_next.valid = s.valid;
        dv0_next.func  = s.func;
        dv0_next.eq    = s.eq;
        dv0_next.r     = s.r;
        dv0_next.a     = s.a;
        dv0_next.rem   = '0;
        dv0_next.q     = '0;
        if (s.func == FN_MAG || s.func == FN_DIST) begin
            dv0_next.sc = sat_w($signed({{(SUMW-QB){1'b0}}, s.root}));
        end else begin
            dv0_next.sc = s.sc;
        end
        for (int i = 0; i < 3; i++) begin
            if (s.func == FN_NORM) begin
                dn  = s.root;
                dng = 1'b0;
            end else begin
                dn  = s.den[i];
                dng = s.den_neg[i];
            end
            ma = s.a[i][W-1] ? W'(0) - s.a[i] : s.a[i];
            dv0_next.den[i] = dn;
            dv0_next.neg[i] = s.a[i][W-1] ^ dng;
            dv0_next.dzc[i] = (dn == '0);
            dv0_next.num[i] = {ma, {F{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0].valid <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= dv0_next;
        end
    end

    // one quotient bit per stage on each component
    function automatic dv_t div_step(input dv_t cur);
        dv_t nxt;
        logic [REMW-1:0] rem2;
        nxt = cur;
        for (int i = 0; i < 3; i++) begin
            rem2 = {cur.rem[i][REMW-2:0], cur.num[i][NB-1]};
            nxt.num[i] = {cur.num[i][NB-2:0], 1'b0};
            if (rem2 >= {1'b0, cur.den[i]}) begin
                nxt.rem[i] = rem2 - {1'b0, cur.den[i]};
                nxt.q[i]   = {cur.q[i][NB-2:0], 1'b1};
            end else begin
                nxt.rem[i] = rem2;
                nxt.q[i]   = {cur.q[i][NB-2:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    for (genvar k = 0; k < NB; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[k+1].valid <= 1'b0;
            end else if (adv) begin
                dv_reg[k+1] <= div_step(dv_reg[k]);
            end
        end
    end

    // ---------------- output register ------------------------------------
    logic              m_valid_reg;
    logic [2:0][W-1:0] r_reg, r_next;
    logic [W-1:0]      sc_reg;
    logic              eq_reg, dz_reg, dz_next;

    always_comb begin
        dv_t d;
        logic          divop;
        logic [W-1:0]  qr;
        d = dv_reg[NB];
        divop = (d.func == FN_DIV) || (d.func == FN_SDIV) || (d.func == FN_NORM);
        dz_next = divop && (d.dzc != 3'b000);
        for (int i = 0; i < 3; i++) begin
            if (d.dzc[i]) begin
                if (d.a[i][W-1]) begin
                    qr = WMIN_W;
                end else if (d.a[i] != '0) begin
                    qr = WMAX_W;
                end else begin
                    qr = '0;
                end
            end else if (d.neg[i]) begin
                qr = (d.q[i] > NB'(WMIN_W)) ? WMIN_W : W'(0) - d.q[i][W-1:0];
            end else begin
                qr = (d.q[i] > NB'(WMAX_W)) ? WMAX_W : d.q[i][W-1:0];
            end
            r_next[i] = divop ? qr : d.r[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_reg[NB].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_reg  <= r_next;
            sc_reg <= dv_reg[NB].sc;
            eq_reg <= dv_reg[NB].eq;
            dz_reg <= dz_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_r_x      = r_reg[0];
    assign m_r_y      = r_reg[1];
    assign m_r_z      = r_reg[2];
    assign m_r_scalar = sc_reg;
    assign m_is_equal = eq_reg;
    assign m_div_zero = dz_reg;

    // ---------------- assertions ------------------------------------------
    a_scalar_or_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_r_scalar != '0) |-> (m_r_x == '0) && (m_r_y == '0) && (m_r_z == '0))
        else $error("scalar and vector results both nonzero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_sqrt_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && sq_reg[0].valid |=> sq_reg[1].valid)
        else $error("word lost entering square root stages");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dv_reg[NB].valid |=> m_valid)
        else $error("word lost at output register");

endmodule
`default_nettype wire
